@@ rtl/quaternion_to_rotation_matrix_defines.svh @@
// assertion macros for the quaternion to rotation matrix block
`ifndef QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH
`define QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, disabled while reset is low
`define QTRM_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("qtrm assertion failed");

// next-cycle implication, disabled while reset is low
`define QTRM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("qtrm assertion failed");

`else

`define QTRM_ASSERT_SAME(label, clk, rstn, ante, cons)
`define QTRM_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/qtrm_pkg.sv @@
`timescale 1ns / 1ps

package qtrm_pkg;

    localparam int NUM_COMPONENTS = 4;
    localparam int NUM_PRODUCTS   = 9;
    localparam int NUM_ENTRIES    = 9;

    // quaternion components in tdata order
    localparam int Q_X = 0;
    localparam int Q_Y = 1;
    localparam int Q_Z = 2;
    localparam int Q_W = 3;

    // pairwise products
    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_XY = 3;
    localparam int P_XZ = 4;
    localparam int P_YZ = 5;
    localparam int P_WX = 6;
    localparam int P_WY = 7;
    localparam int P_WZ = 8;

    localparam int PROD_L [NUM_PRODUCTS] = '{Q_X, Q_Y, Q_Z, Q_X, Q_X, Q_Y, Q_W, Q_W, Q_W};
    localparam int PROD_R [NUM_PRODUCTS] = '{Q_X, Q_Y, Q_Z, Q_Y, Q_Z, Q_Z, Q_X, Q_Y, Q_Z};

    // matrix entries, row major: r00 r01 r02 r10 r11 r12 r20 r21 r22
    localparam int ENTRY_A [NUM_ENTRIES] =
        '{P_YY, P_XY, P_XZ, P_XY, P_XX, P_YZ, P_XZ, P_YZ, P_XX};
    localparam int ENTRY_B [NUM_ENTRIES] =
        '{P_ZZ, P_WZ, P_WY, P_WZ, P_ZZ, P_WX, P_WY, P_WX, P_YY};

    // diagonal: one minus both terms; otherwise a plus or minus b
    localparam logic [NUM_ENTRIES-1:0] ENTRY_DIAG  = 9'b100_010_001;
    localparam logic [NUM_ENTRIES-1:0] ENTRY_NEG_B = 9'b001_100_010;

endpackage

@@ rtl/qtrm_products.sv @@
`timescale 1ns / 1ps

module qtrm_products #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]  q [qtrm_pkg::NUM_COMPONENTS],
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [2*SAMPLE_WIDTH-1:0] p [qtrm_pkg::NUM_PRODUCTS]
);

    localparam int PW = 2 * SAMPLE_WIDTH;

    logic                 valid_reg;
    logic signed [PW-1:0] prod_reg  [qtrm_pkg::NUM_PRODUCTS];
    logic signed [PW-1:0] prod_next [qtrm_pkg::NUM_PRODUCTS];
    logic                 advance;

    assign advance   = !valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = valid_reg;
    assign p         = prod_reg;

    always_comb begin
        for (int i = 0; i < qtrm_pkg::NUM_PRODUCTS; i++) begin
            prod_next[i] = PW'(q[qtrm_pkg::PROD_L[i]]) * PW'(q[qtrm_pkg::PROD_R[i]]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            prod_reg <= prod_next;
        end
    end

endmodule

@@ rtl/qtrm_combine.sv @@
`timescale 1ns / 1ps

module qtrm_combine #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [2*SAMPLE_WIDTH-1:0] p [qtrm_pkg::NUM_PRODUCTS],
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [2*SAMPLE_WIDTH+1:0] s [qtrm_pkg::NUM_ENTRIES]
);

    localparam int SW = 2 * SAMPLE_WIDTH + 2;
    // rounding half and one, both scaled to the product sum before the shift
    localparam logic signed [SW-1:0] K_HALF = SW'(1) << (SAMPLE_WIDTH - 4);
    localparam logic signed [SW-1:0] K_ONE  = SW'(1) << (2 * SAMPLE_WIDTH - 5);

    logic                 valid_reg;
    logic signed [SW-1:0] sum_reg  [qtrm_pkg::NUM_ENTRIES];
    logic signed [SW-1:0] sum_next [qtrm_pkg::NUM_ENTRIES];
    logic                 advance;

    assign advance   = !valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = valid_reg;
    assign s         = sum_reg;

    always_comb begin
        logic signed [SW-1:0] a;
        logic signed [SW-1:0] b;
        for (int e = 0; e < qtrm_pkg::NUM_ENTRIES; e++) begin
            a = SW'(p[qtrm_pkg::ENTRY_A[e]]);
            b = SW'(p[qtrm_pkg::ENTRY_B[e]]);
            if (qtrm_pkg::ENTRY_DIAG[e]) begin
                sum_next[e] = K_ONE + K_HALF - a - b;
            end else if (qtrm_pkg::ENTRY_NEG_B[e]) begin
                sum_next[e] = a - b + K_HALF;
            end else begin
                sum_next[e] = a + b + K_HALF;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            sum_reg <= sum_next;
        end
    end

endmodule

@@ rtl/qtrm_saturate.sv @@
`timescale 1ns / 1ps

module qtrm_saturate #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [2*SAMPLE_WIDTH+1:0] s [qtrm_pkg::NUM_ENTRIES],
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]   r [qtrm_pkg::NUM_ENTRIES]
);

    localparam int W  = SAMPLE_WIDTH;
    localparam int SW = 2 * SAMPLE_WIDTH + 2;
    localparam int RSHIFT = SAMPLE_WIDTH - 3;
    localparam logic signed [SW-1:0] MAX_V = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] MIN_V = -MAX_V - SW'(1);

    logic                 valid_reg;
    logic signed [W-1:0]  r_reg  [qtrm_pkg::NUM_ENTRIES];
    logic signed [W-1:0]  r_next [qtrm_pkg::NUM_ENTRIES];
    logic                 advance;

    assign advance   = !valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = valid_reg;
    assign r         = r_reg;

    always_comb begin
        logic signed [SW-1:0] t;
        for (int e = 0; e < qtrm_pkg::NUM_ENTRIES; e++) begin
            t = s[e] >>> RSHIFT;
            if (t > MAX_V) begin
                r_next[e] = MAX_V[W-1:0];
            end else if (t < MIN_V) begin
                r_next[e] = MIN_V[W-1:0];
            end else begin
                r_next[e] = t[W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            r_reg <= r_next;
        end
    end

endmodule

@@ rtl/quaternion_to_rotation_matrix.sv @@
// Quaternion to 3x3 rotation matrix. Each input beat carries one quaternion
// (x, y, z, w) in signed fixed point with SAMPLE_WIDTH-2 fraction bits; each
// output beat carries the nine matrix entries in the same format, row major,
// rounded half up and saturated. The quaternion is used as given, without
// normalization. The block takes one beat every cycle while the pipeline is not
// full; a result passes through the input register, nine multipliers, add and
// round, and shift and saturate into the output register. Back pressure on the
// output stalls only as far back as needed: empty stages keep filling.
`timescale 1ns / 1ps
`include "quaternion_to_rotation_matrix_defines.svh"

module quaternion_to_rotation_matrix #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // qx, qy, qz, qw, zero padding to whole bytes
    input  logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0]         s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // r00, r01, r02, r10, r11, r12, r20, r21, r22, zero padding to whole bytes
    output logic [((9*SAMPLE_WIDTH+7)/8)*8-1:0]         m_tdata
);

    localparam int W    = SAMPLE_WIDTH;
    localparam int M_DW = ((9 * SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int M_FW = qtrm_pkg::NUM_ENTRIES * SAMPLE_WIDTH;

    logic                  in_valid_reg;
    logic signed [W-1:0]   q_reg [qtrm_pkg::NUM_COMPONENTS];
    logic                  in_advance;

    logic                   prod_ready;
    logic                   prod_valid;
    logic signed [2*W-1:0]  prod [qtrm_pkg::NUM_PRODUCTS];
    logic                   comb_ready;
    logic                   comb_valid;
    logic signed [2*W+1:0]  sums [qtrm_pkg::NUM_ENTRIES];
    logic                   sat_ready;
    logic signed [W-1:0]    entries [qtrm_pkg::NUM_ENTRIES];

    assign in_advance = !in_valid_reg || prod_ready;
    assign s_tready   = in_advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_advance) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_advance && s_tvalid) begin
            for (int i = 0; i < qtrm_pkg::NUM_COMPONENTS; i++) begin
                q_reg[i] <= s_tdata[i*W +: W];
            end
        end
    end

    qtrm_products #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_products (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_ready  (prod_ready),
        .q         (q_reg),
        .out_valid (prod_valid),
        .out_ready (comb_ready),
        .p         (prod)
    );

    qtrm_combine #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_combine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (comb_ready),
        .p         (prod),
        .out_valid (comb_valid),
        .out_ready (sat_ready),
        .s         (sums)
    );

    qtrm_saturate #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_saturate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (comb_valid),
        .in_ready  (sat_ready),
        .s         (sums),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .r         (entries)
    );

    for (genvar e = 0; e < qtrm_pkg::NUM_ENTRIES; e++) begin : g_pack
        assign m_tdata[e*W +: W] = entries[e];
    end

    if (M_DW > M_FW) begin : g_pad
        assign m_tdata[M_DW-1:M_FW] = '0;
    end

    // a full pipeline is the only reason to refuse a beat
    `QTRM_ASSERT_SAME(a_full_when_blocked, aclk, aresetn, !s_tready,
        in_valid_reg && prod_valid && comb_valid && m_tvalid && !m_tready)

    // a held quaternion stays put until the product stage takes it
    `QTRM_ASSERT_NEXT(a_input_holds, aclk, aresetn, in_valid_reg && !prod_ready,
        in_valid_reg && $stable(q_reg[qtrm_pkg::Q_X]) && $stable(q_reg[qtrm_pkg::Q_W]))

    // a stalled sum stage keeps its beat
    `QTRM_ASSERT_NEXT(a_sum_holds, aclk, aresetn, comb_valid && !sat_ready,
        comb_valid && $stable(sums[0]))

endmodule
